>>> hw/rtl/gn2d_pkg.sv
// shared constants for the 2d gradient noise block
`timescale 1ns / 1ps
package gn2d_pkg;
  localparam int unsigned GRID_X_DEF = 16;
  localparam int unsigned GRID_Y_DEF = 16;
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;
endpackage

>>> hw/rtl/gradient_noise_2d.sv
// 2d gradient noise evaluator with lattice gradient store
//
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | func, lattice_index, grad_x/y, x/y_coord
// out     | out | out_valid/out_ready| noise_value
//
// one item per cycle unless the output register is held with out_ready low
// the gradient store has four read copies, one per corner, so no item waits on a port
// rst_n clears only valid bits; the store holds garbage until written
// a stall freezes the whole pipeline; in_ready follows out_ready and the output slot
`timescale 1ns / 1ps
module gradient_noise_2d
  import gn2d_pkg::*;
#(
  parameter int unsigned GRID_X = GRID_X_DEF,
  parameter int unsigned GRID_Y = GRID_Y_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [8:0]         in_lattice_index,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic [15:0]        in_x_coord,
  input  logic [15:0]        in_y_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_noise_value
);
  localparam int unsigned LatW  = GRID_X + 1;
  localparam int unsigned Depth = (GRID_X + 1) * (GRID_Y + 1);
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [15:0] XMAX  = 16'(GRID_X * 256 - 1);
  localparam logic [15:0] YMAX  = 16'(GRID_Y * 256 - 1);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [31:0] mem0 [Depth];
  logic [31:0] mem1 [Depth];
  logic [31:0] mem2 [Depth];
  logic [31:0] mem3 [Depth];

  // stage 1: saturate and address, gradient store write
  logic v1_r;
  logic [AW-1:0] a00_r, a10_r, a01_r, a11_r;
  logic [7:0] fx1_r, fy1_r;
  logic [15:0] xs, ys;
  logic [AW+8:0] base;
  assign xs = (in_x_coord > XMAX) ? XMAX : in_x_coord;
  assign ys = (in_y_coord > YMAX) ? YMAX : in_y_coord;
  assign base = (AW+9)'(ys[15:8]) * (AW+9)'(LatW) + (AW+9)'(xs[15:8]);

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid && (in_func == FUNC_EVAL);
    if (adv) begin
      a00_r <= AW'(base);
      a10_r <= AW'(base + 1);
      a01_r <= AW'(base + (AW+9)'(LatW));
      a11_r <= AW'(base + (AW+9)'(LatW) + 1);
      fx1_r <= xs[7:0];
      fy1_r <= ys[7:0];
    end
    if (in_valid && adv && in_func == FUNC_WRITE && 32'(in_lattice_index) < Depth) begin
      mem0[AW'(in_lattice_index)] <= {in_grad_x, in_grad_y};
      mem1[AW'(in_lattice_index)] <= {in_grad_x, in_grad_y};
      mem2[AW'(in_lattice_index)] <= {in_grad_x, in_grad_y};
      mem3[AW'(in_lattice_index)] <= {in_grad_x, in_grad_y};
    end
  end

  // stage 2: memory read, fade square
  logic v2_r;
  logic [31:0] g00_r, g10_r, g01_r, g11_r;
  logic [7:0] fx2_r, fy2_r;
  logic [15:0] tx2_r, ty2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      g00_r <= mem0[a00_r];
      g10_r <= mem1[a10_r];
      g01_r <= mem2[a01_r];
      g11_r <= mem3[a11_r];
      fx2_r <= fx1_r;
      fy2_r <= fy1_r;
      tx2_r <= fx1_r * fx1_r;
      ty2_r <= fy1_r * fy1_r;
    end
  end

  // stage 3: dot products, fade
  logic v3_r;
  logic signed [26:0] n00_r, n10_r, n01_r, n11_r;
  logic [24:0] sx3_r, sy3_r;
  logic signed [9:0] dx0, dx1, dy0, dy1;
  assign dx0 = {2'b00, fx2_r};
  assign dx1 = {2'b00, fx2_r} - 10'sd256;
  assign dy0 = {2'b00, fy2_r};
  assign dy1 = {2'b00, fy2_r} - 10'sd256;

  function automatic logic signed [26:0] dot(input logic signed [9:0] dx,
      input logic signed [9:0] dy, input logic [31:0] g);
    logic signed [25:0] px, py;
    px = dx * $signed(g[31:16]);
    py = dy * $signed(g[15:0]);
    return 27'(px) + 27'(py);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      n00_r <= dot(dx0, dy0, g00_r);
      n10_r <= dot(dx1, dy0, g10_r);
      n01_r <= dot(dx0, dy1, g01_r);
      n11_r <= dot(dx1, dy1, g11_r);
      sx3_r <= 25'(tx2_r) * 25'(10'd768 - {1'b0, fx2_r, 1'b0});
      sy3_r <= 25'(ty2_r) * 25'(10'd768 - {1'b0, fy2_r, 1'b0});
    end
  end

  // stage 4: x lerp products
  logic v4_r;
  logic signed [52:0] p0_r, p1_r;
  logic [24:0] sy4_r;
  logic signed [25:0] sxs, sxc;
  assign sxs = $signed({1'b0, sx3_r});
  assign sxc = 26'sd16777216 - sxs;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
    if (adv) begin
      p0_r  <= 53'(n00_r) * 53'(sxc) + 53'(n10_r) * 53'(sxs);
      p1_r  <= 53'(n01_r) * 53'(sxc) + 53'(n11_r) * 53'(sxs);
      sy4_r <= sy3_r;
    end
  end

  // stage 5: y lerp products
  logic v5_r;
  logic signed [53:0] q_r;
  logic signed [28:0] b0, b1;
  logic signed [25:0] sys, syc;
  assign b0  = 29'(p0_r >>> 24);
  assign b1  = 29'(p1_r >>> 24);
  assign sys = $signed({1'b0, sy4_r});
  assign syc = 26'sd16777216 - sys;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
    if (adv) q_r <= 54'(b0) * 54'(syc) + 54'(b1) * 54'(sys);
  end

  // stage 6: floor and saturate
  logic signed [21:0] vq;
  assign vq = 22'(q_r >>> 32);
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= v5_r;
    if (adv) begin
      if (vq > 22'sd32767) out_noise_value <= 16'sh7fff;
      else if (vq < -22'sd32768) out_noise_value <= 16'sh8000;
      else out_noise_value <= vq[15:0];
    end
  end
endmodule
